>>> hdl/kdlp_pkg.sv
// shared types and constants for the key debounce and long-press detector
package kdlp_pkg;

  // key event codes
  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_SHORT = 2'd1;
  localparam logic [1:0] EVT_LONG  = 2'd2;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS = 2'd1;

  // register widths and reset values
  localparam int CFG_DATA_W   = 16;
  localparam int DEBOUNCE_W   = 10;
  localparam int LONG_PRESS_W = 16;
  localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RST   = 10'd20;
  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RST = 16'd2000;

  // one result item
  typedef struct packed {
    logic       long_held;
    logic       stable_pressed;
    logic [1:0] key_event;
  } key_result_t;

endpackage

>>> hdl/key_debounce_long_press.sv
// key debounce with short and long press detection, one tick per transfer
//
// Each input transfer is one millisecond tick carrying the raw active-low key
// level; each one produces exactly one result transfer. The block takes one
// tick per clock cycle: the whole update of the edge age, the hold age and the
// debounced level is one layer of counter increments and compares between the
// state registers and the result register, so a new tick is taken in every
// cycle in which the result register is empty or being drained. Both ages
// saturate at 2^COUNT_WIDTH-1. The user writes configuration through
// cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce this.
module key_debounce_long_press
  import kdlp_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input ticks
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] raw_level, [7:1] zero
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata   // [1:0] key_event, [2] stable_pressed,
                                            // [3] long_held, [7:4] zero
);

  localparam int CMP_W = (COUNT_WIDTH > LONG_PRESS_W) ? COUNT_WIDTH : LONG_PRESS_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // saturating increment of an age counter
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
  endfunction

  logic [DEBOUNCE_W-1:0]   debounce_r;
  logic [LONG_PRESS_W-1:0] long_press_r;

  logic                    last_raw_r, last_raw_nxt;
  logic                    stable_r, stable_nxt;
  logic [COUNT_WIDTH-1:0]  edge_age_r, edge_age_nxt;
  logic [COUNT_WIDTH-1:0]  hold_age_r, hold_age_nxt;
  logic                    fired_r, fired_nxt;

  logic                    out_valid_r;
  key_result_t             out_data_r, res_nxt;

  logic                    in_xfer;
  logic                    raw;
  logic                    accept_lvl;
  logic [1:0]              evt;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign raw        = in_tdata[0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[DEBOUNCE_W-1:0];
        CFG_LONG_PRESS: long_press_r <= cfg_wdata[LONG_PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // next state and result for one tick
  always_comb begin
    last_raw_nxt = raw;
    edge_age_nxt = (raw != last_raw_r) ? '0 : sat_inc(edge_age_r);
    hold_age_nxt = sat_inc(hold_age_r);
    stable_nxt   = stable_r;
    fired_nxt    = fired_r;
    evt          = EVT_NONE;

    // debounced level change
    accept_lvl = (CMP_W'(edge_age_nxt) >= CMP_W'(debounce_r)) && (raw != stable_r);
    if (accept_lvl) begin
      stable_nxt = raw;
      if (!raw) begin
        hold_age_nxt = '0;
        fired_nxt    = 1'b0;
      end else if (!fired_r) begin
        evt = EVT_SHORT;
      end
    end

    // long-press detection
    if (!stable_nxt && !fired_nxt && (CMP_W'(hold_age_nxt) >= CMP_W'(long_press_r))) begin
      fired_nxt = 1'b1;
      evt       = EVT_LONG;
    end

    res_nxt.key_event      = evt;
    res_nxt.stable_pressed = !stable_nxt;
    res_nxt.long_held      = fired_nxt;
  end

  // key state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      stable_r   <= 1'b1;
      edge_age_r <= '0;
      hold_age_r <= '0;
      fired_r    <= 1'b0;
    end else if (in_xfer) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      edge_age_r <= edge_age_nxt;
      hold_age_r <= hold_age_nxt;
      fired_r    <= fired_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res_nxt;
    end
  end

  // a long-press event always comes with the key held and the flag set
  a_long_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.key_event == EVT_LONG)
      |-> out_data_r.stable_pressed && out_data_r.long_held)
    else $error("long-press event without held key or flag");

  // a short-press event only on a release with no long press
  a_short_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.key_event == EVT_SHORT)
      |-> !out_data_r.stable_pressed && !out_data_r.long_held)
    else $error("short-press event while pressed or after long press");

  // every accepted tick leaves a result waiting
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("input transfer without result");

  // the long-press flag never sets while the key is released
  a_fired_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fired_r) |-> !stable_r)
    else $error("long-press flag set while released");

endmodule

>>> test/tb.sv
// self-checking bench for the key debounce and long-press detector
module tb;
  import kdlp_pkg::*;

  localparam int CNT_W      = 16;
  localparam int QUIET_MAX  = 2000;
  localparam int SETTLE     = 4;
  localparam int IDLE_PCT   = 38;
  localparam int RAND_TICKS = 600;
  // register indexes that map to nothing
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [0] raw_level, [7:1] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [1:0] key_event, [2] stable_pressed,
                                          // [3] long_held, [7:4] zero

  // raw levels waiting to be sent and key results still due
  logic        raw_ticks[$];
  key_result_t expected_keys[$];

  // shadow registers and debouncer state of the predictor
  logic [DEBOUNCE_W-1:0]   set_debounce;
  logic [LONG_PRESS_W-1:0] set_long_press;
  logic                    prev_raw;
  logic                    settled_level;
  logic [CNT_W-1:0]        raw_age;
  logic [CNT_W-1:0]        press_age;
  logic                    long_seen;

  bit steady = 1'b0;
  int errors = 0;
  int ticks_sent = 0;
  int ticks_queued = 0;
  int results_seen = 0;
  int shorts_seen = 0;
  int longs_seen = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  key_debounce_long_press #(.COUNT_WIDTH(CNT_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // one tick of the debouncer: age counters, acceptance, then the hold compare
  function automatic key_result_t predict_key(logic raw);
    key_result_t r;
    r.key_event = EVT_NONE;
    if (raw != prev_raw) begin
      prev_raw = raw;
      raw_age = '0;
    end else if (raw_age != '1) begin
      raw_age++;
    end
    if (press_age != '1) press_age++;
    if (raw_age >= set_debounce && raw != settled_level) begin
      settled_level = raw;
      if (!raw) begin
        press_age = '0;
        long_seen = 1'b0;
      end else if (!long_seen) begin
        r.key_event = EVT_SHORT;
      end
    end
    if (!settled_level && !long_seen && press_age >= set_long_press) begin
      long_seen = 1'b1;
      r.key_event = EVT_LONG;
    end
    r.stable_pressed = ~settled_level;
    r.long_held = long_seen;
    return r;
  endfunction

  // shadow copy of the register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      set_debounce   <= DEBOUNCE_RST;
      set_long_press <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEBOUNCE:   set_debounce   <= cfg_wdata[DEBOUNCE_W-1:0];
        CFG_LONG_PRESS: set_long_press <= cfg_wdata[LONG_PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // tick driver: predicts on every input transfer, then offers the next tick
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      prev_raw = 1'b1;
      settled_level = 1'b1;
      raw_age = '0;
      press_age = '0;
      long_seen = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_keys.push_back(predict_key(in_tdata[0]));
        ticks_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (raw_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, raw_ticks.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: field by field against the oldest expectation
  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[3:0];
        results_seen++;
        if (got.key_event == EVT_SHORT) shorts_seen++;
        if (got.key_event == EVT_LONG) longs_seen++;
        if (expected_keys.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", results_seen));
        end else begin
          want = expected_keys.pop_front();
          if (got.key_event != want.key_event)
            report_mismatch($sformatf("result %0d key_event %0d, expected %0d",
                                      results_seen, got.key_event, want.key_event));
          if (got.stable_pressed != want.stable_pressed)
            report_mismatch($sformatf("result %0d stable_pressed %0b, expected %0b",
                                      results_seen, got.stable_pressed,
                                      want.stable_pressed));
          if (got.long_held != want.long_held)
            report_mismatch($sformatf("result %0d long_held %0b, expected %0b",
                                      results_seen, got.long_held, want.long_held));
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // both registers, debounce with junk above its width
  task automatic set_timing(int unsigned db, int unsigned lp);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom);
    w[DEBOUNCE_W-1:0] = DEBOUNCE_W'(db);
    write_reg(CFG_DEBOUNCE, w);
    write_reg(CFG_LONG_PRESS, CFG_DATA_W'(lp));
    settings_used++;
  endtask

  task automatic push_run(logic level, int unsigned n);
    repeat (n) raw_ticks.push_back(level);
    ticks_queued += n;
  endtask

  // sender holds off until every result is in, then lets the pipe settle
  task automatic wait_drained();
    do @(posedge clk);
    while (raw_ticks.size() != 0 || in_tvalid || expected_keys.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // contact bounce: short alternating runs starting at the given level
  task automatic add_bounce(logic level);
    repeat ($urandom_range(0, 3)) begin
      push_run(level, $urandom_range(1, 2));
      push_run(~level, $urandom_range(1, 2));
    end
  endtask

  // one key gesture sized to the current timing, or plain noise
  task automatic add_gesture(int unsigned db, int unsigned lp);
    int unsigned hold;
    case ($urandom_range(0, 9))
      0, 1: begin
        repeat ($urandom_range(1, 8)) push_run(1'($urandom_range(0, 1)), 1);
      end
      2: begin
        push_run(1'b0, $urandom_range(1, db > 1 ? db : 1));
        push_run(1'b1, $urandom_range(1, db + 2));
      end
      default: begin
        add_bounce(1'b0);
        if ($urandom_range(0, 1) || lp > 2100)
          hold = db + 1 + $urandom_range(0, lp < 60 ? lp : 60);
        else
          hold = db + lp + $urandom_range(0, 8);
        push_run(1'b0, hold);
        add_bounce(1'b1);
        push_run(1'b1, db + 1 + $urandom_range(0, 6));
      end
    endcase
  endtask

  initial begin
    int unsigned db;
    int unsigned lp;
    int rand_start;
    int phase_start;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset timing: bounced short presses and a pulse shorter than the debounce time
    repeat (2) begin
      add_bounce(1'b0);
      push_run(1'b0, 35);
      add_bounce(1'b1);
      push_run(1'b1, 25);
    end
    push_run(1'b0, 10);
    push_run(1'b1, 25);
    wait_drained();

    // zero debounce and zero hold time, release after a long press
    set_timing(0, 0);
    push_run(1'b0, 2);
    push_run(1'b1, 2);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    wait_drained();

    // bounce rejected, release on the tick the hold time is reached,
    // then a long press exactly at the hold time; spare indexes ignored
    set_timing(2, 3);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 3);
    push_run(1'b1, 3);
    push_run(1'b0, 6);
    push_run(1'b1, 3);
    wait_drained();

    // widest settings, then a run of gestures, all with no idling at all
    steady = 1'b1;
    set_timing(1023, 65535);
    push_run(1'b0, 40);
    push_run(1'b1, 20);
    wait_drained();
    set_timing(4, 30);
    phase_start = ticks_queued;
    while (ticks_queued - phase_start < 150) add_gesture(4, 30);
    wait_drained();
    steady = 1'b0;

    // random gestures over a spread of timings
    rand_start = ticks_queued;
    while (ticks_queued - rand_start < RAND_TICKS) begin
      db = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      lp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 25);
      set_timing(db, lp);
      phase_start = ticks_queued;
      while (ticks_queued - phase_start < 150) add_gesture(db, lp);
      wait_drained();
    end

    if (expected_keys.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_keys.size()));
    $display("ticks %0d over %0d timing settings, zero and widest debounce and hold included",
             ticks_sent, settings_used);
    $display("results %0d checked, %0d short presses and %0d long presses among them",
             results_seen, shorts_seen, longs_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
